### hdl/enct_pkg.sv
// Shared types, constants and a helper function for the event notification table.
`default_nettype none

package enct_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int OP_W   = 2;
  localparam int KEY_W  = 15;
  localparam int PID_W  = 15;
  localparam int SIG_W  = 8;
  localparam int EV_W   = 8;
  localparam int QUAL_W = 32;

  localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(TABLE_ENTRIES);
  localparam logic [KEY_W-1:0] KEY_MAX     = {KEY_W{1'b1}};

  localparam logic [OP_W-1:0] OP_SETUP    = 2'd0;
  localparam logic [OP_W-1:0] OP_TEARDOWN = 2'd1;
  localparam logic [OP_W-1:0] OP_SIGNAL   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_NOENTRY = 2'd2,
    ST_NOTIFY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [PID_W-1:0]  pid;
    logic [SIG_W-1:0]  sig;
    logic [EV_W-1:0]   ev;
    logic [QUAL_W-1:0] qual;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             push;
    logic             keep;
    logic             drop;
    logic             restart;
    logic             commit;
    logic [IDX_W-1:0] slot;
  } ord_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             full;
    logic [IDX_W-1:0] free_slot;
    logic [IDX_W-1:0] rd_slot;
  } ord_stat_t;

  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [KEY_W-1:0]  new_key;
    logic [PID_W-1:0]  pid;
    logic [SIG_W-1:0]  sig;
    logic [QUAL_W-1:0] qual;
    logic              last;
  } result_t;

  // Wrapping key counter step: keys run from 1 up to KEY_MAX.
  function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] k);
    if (k >= KEY_MAX) begin
      return KEY_W'(1);
    end
    return k + KEY_W'(1);
  endfunction

endpackage

`default_nettype wire

### hdl/enct_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module enct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                       clk,
  input  wire logic                                       wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                           wr_data,
  input  wire logic                                       rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/enct_order.sv
// Age-ordered list of occupied slots (newest first), entry valid bits and free slot search.
`default_nettype none

module enct_order (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire enct_pkg::ord_cmd_t        cmd,
  input  wire logic [enct_pkg::IDX_W-1:0] rd_pos,
  output enct_pkg::ord_stat_t            stat
);

  logic [enct_pkg::IDX_W-1:0]         order_r [enct_pkg::TABLE_ENTRIES];
  logic [enct_pkg::TABLE_ENTRIES-1:0] valid_r;
  logic [enct_pkg::CNT_W-1:0]         count_r;
  logic [enct_pkg::CNT_W-1:0]         wp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      wp_r    <= '0;
    end else begin
      if (cmd.restart) begin
        wp_r <= '0;
      end else if (cmd.keep) begin
        wp_r <= wp_r + enct_pkg::CNT_W'(1);
      end
      if (cmd.push) begin
        count_r          <= count_r + enct_pkg::CNT_W'(1);
        valid_r[cmd.slot] <= 1'b1;
      end else if (cmd.commit) begin
        count_r <= wp_r;
      end
      if (cmd.drop) begin
        valid_r[cmd.slot] <= 1'b0;
      end
    end
  end

  // Survivors are packed toward the front while the list is walked; a new
  // entry goes in at the front and pushes the others back by one place.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      order_r[0] <= cmd.slot;
      for (int j = 1; j < enct_pkg::TABLE_ENTRIES; j++) begin
        order_r[j] <= order_r[j-1];
      end
    end else if (cmd.keep) begin
      order_r[wp_r[enct_pkg::IDX_W-1:0]] <= cmd.slot;
    end
  end

  always_comb begin
    stat.free_slot = '0;
    for (int i = enct_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        stat.free_slot = enct_pkg::IDX_W'(i);
      end
    end
    stat.count   = count_r;
    stat.full    = (count_r == enct_pkg::ENTRIES_CNT);
    stat.rd_slot = order_r[rd_pos];
  end

endmodule

`default_nettype wire

### hdl/enct_seq.sv
// Request sequencer: walks the age list, reads entries from the RAM and issues result words.
`default_nettype none

module enct_seq (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [enct_pkg::OP_W-1:0]    in_op,
  input  wire logic [enct_pkg::PID_W-1:0]   in_target_pid,
  input  wire logic [enct_pkg::PID_W-1:0]   in_caller_pid,
  input  wire logic [enct_pkg::SIG_W-1:0]   in_signal_number,
  input  wire logic [enct_pkg::EV_W-1:0]    in_event_type,
  input  wire logic [enct_pkg::QUAL_W-1:0]  in_qualifier,
  input  wire logic [enct_pkg::KEY_W-1:0]   in_lookup_key,
  input  wire enct_pkg::ord_stat_t          ord_stat,
  output enct_pkg::ord_cmd_t                ord_cmd,
  output logic [enct_pkg::IDX_W-1:0]        ord_rd_pos,
  output logic                              ram_rd_en,
  output logic [enct_pkg::IDX_W-1:0]        ram_rd_addr,
  input  wire enct_pkg::entry_t             ram_rd_data,
  output logic                              ram_wr_en,
  output logic [enct_pkg::IDX_W-1:0]        ram_wr_addr,
  output enct_pkg::entry_t                  ram_wr_data,
  input  wire logic                         out_free,
  output enct_pkg::result_t                 res
);

  enct_pkg::seq_state_t             state_r, state_nxt;
  logic [enct_pkg::OP_W-1:0]        op_r, op_nxt;
  logic [enct_pkg::PID_W-1:0]       pid_r, pid_nxt;
  logic [enct_pkg::SIG_W-1:0]       sig_r, sig_nxt;
  logic [enct_pkg::EV_W-1:0]        ev_r, ev_nxt;
  logic [enct_pkg::QUAL_W-1:0]      qual_r, qual_nxt;
  logic [enct_pkg::KEY_W-1:0]       lkey_r, lkey_nxt;
  logic [enct_pkg::KEY_W-1:0]       kc_r, kc_nxt;
  logic [enct_pkg::IDX_W-1:0]       pos_r, pos_nxt;
  logic [enct_pkg::IDX_W-1:0]       cur_slot_r, cur_slot_nxt;
  logic [enct_pkg::IDX_W-1:0]       slot_r, slot_nxt;
  logic                             found_r, found_nxt;
  logic                             nospace_r, nospace_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= enct_pkg::S_IDLE;
      kc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      kc_r    <= kc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pid_r      <= pid_nxt;
    sig_r      <= sig_nxt;
    ev_r       <= ev_nxt;
    qual_r     <= qual_nxt;
    lkey_r     <= lkey_nxt;
    pos_r      <= pos_nxt;
    cur_slot_r <= cur_slot_nxt;
    slot_r     <= slot_nxt;
    found_r    <= found_nxt;
    nospace_r  <= nospace_nxt;
  end

  assign in_stall    = (state_r != enct_pkg::S_IDLE);
  assign ram_rd_addr = ord_stat.rd_slot;
  assign ram_wr_addr = slot_r;

  always_comb begin
    logic last_pos;
    logic adv;

    state_nxt    = state_r;
    op_nxt       = op_r;
    pid_nxt      = pid_r;
    sig_nxt      = sig_r;
    ev_nxt       = ev_r;
    qual_nxt     = qual_r;
    lkey_nxt     = lkey_r;
    kc_nxt       = kc_r;
    pos_nxt      = pos_r;
    cur_slot_nxt = cur_slot_r;
    slot_nxt     = slot_r;
    found_nxt    = found_r;
    nospace_nxt  = nospace_r;
    ord_cmd      = '0;
    ord_rd_pos   = pos_r;
    ram_rd_en    = 1'b0;
    ram_wr_en    = 1'b0;
    res          = '0;
    adv          = 1'b0;
    last_pos     = ((enct_pkg::CNT_W'(pos_r) + enct_pkg::CNT_W'(1)) == ord_stat.count);

    ram_wr_data.key  = kc_r;
    ram_wr_data.pid  = pid_r;
    ram_wr_data.sig  = sig_r;
    ram_wr_data.ev   = ev_r;
    ram_wr_data.qual = qual_r;

    case (state_r)
      enct_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt          = in_op;
          pid_nxt         = (in_target_pid == '0) ? in_caller_pid : in_target_pid;
          sig_nxt         = in_signal_number;
          ev_nxt          = in_event_type;
          qual_nxt        = in_qualifier;
          lkey_nxt        = in_lookup_key;
          pos_nxt         = '0;
          found_nxt       = 1'b0;
          nospace_nxt     = 1'b0;
          ord_cmd.restart = 1'b1;
          state_nxt       = enct_pkg::S_FINISH;
          case (in_op)
            enct_pkg::OP_SETUP: begin
              if (ord_stat.full) begin
                nospace_nxt = 1'b1;
              end else begin
                kc_nxt   = enct_pkg::next_key(kc_r);
                slot_nxt = ord_stat.free_slot;
                if (ord_stat.count != '0) begin
                  state_nxt = enct_pkg::S_READ;
                end
              end
            end
            enct_pkg::OP_TEARDOWN, enct_pkg::OP_SIGNAL: begin
              if (ord_stat.count != '0) begin
                state_nxt = enct_pkg::S_READ;
              end
            end
            default: begin
              state_nxt = enct_pkg::S_FINISH;
            end
          endcase
        end
      end

      enct_pkg::S_READ: begin
        ord_rd_pos   = pos_r;
        ram_rd_en    = 1'b1;
        cur_slot_nxt = ord_stat.rd_slot;
        state_nxt    = enct_pkg::S_CHECK;
      end

      enct_pkg::S_CHECK: begin
        ord_cmd.slot = cur_slot_r;
        case (op_r)
          enct_pkg::OP_SETUP: begin
            // A candidate key already held by an entry: take the next one
            // and scan the whole list again.
            if (ram_rd_data.key == kc_r) begin
              kc_nxt    = enct_pkg::next_key(kc_r);
              pos_nxt   = '0;
              state_nxt = enct_pkg::S_READ;
            end else begin
              adv = 1'b1;
            end
          end
          enct_pkg::OP_TEARDOWN: begin
            if (ram_rd_data.key == lkey_r) begin
              found_nxt    = 1'b1;
              ord_cmd.drop = 1'b1;
            end else begin
              ord_cmd.keep = 1'b1;
            end
            adv = 1'b1;
          end
          enct_pkg::OP_SIGNAL: begin
            if (ram_rd_data.ev == ev_r && ram_rd_data.qual == qual_r) begin
              // The walk holds here until the output register can take the word.
              if (out_free) begin
                res.valid    = 1'b1;
                res.status   = enct_pkg::ST_NOTIFY;
                res.pid      = ram_rd_data.pid;
                res.sig      = ram_rd_data.sig;
                res.qual     = ram_rd_data.qual;
                ord_cmd.drop = 1'b1;
                adv          = 1'b1;
              end
            end else begin
              ord_cmd.keep = 1'b1;
              adv          = 1'b1;
            end
          end
          default: begin
            state_nxt = enct_pkg::S_FINISH;
          end
        endcase
        if (adv) begin
          if (last_pos) begin
            state_nxt = enct_pkg::S_FINISH;
          end else begin
            pos_nxt      = pos_r + enct_pkg::IDX_W'(1);
            ord_rd_pos   = pos_nxt;
            ram_rd_en    = 1'b1;
            cur_slot_nxt = ord_stat.rd_slot;
          end
        end
      end

      enct_pkg::S_FINISH: begin
        if (out_free) begin
          res.valid  = 1'b1;
          res.last   = 1'b1;
          res.status = enct_pkg::ST_OK;
          state_nxt  = enct_pkg::S_IDLE;
          case (op_r)
            enct_pkg::OP_SETUP: begin
              if (nospace_r) begin
                res.status = enct_pkg::ST_NOSPACE;
              end else begin
                res.new_key  = kc_r;
                ram_wr_en    = 1'b1;
                ord_cmd.push = 1'b1;
                ord_cmd.slot = slot_r;
              end
            end
            enct_pkg::OP_TEARDOWN: begin
              res.status     = found_r ? enct_pkg::ST_OK : enct_pkg::ST_NOENTRY;
              ord_cmd.commit = 1'b1;
            end
            enct_pkg::OP_SIGNAL: begin
              ord_cmd.commit = 1'b1;
            end
            default: begin
              res.status = enct_pkg::ST_OK;
            end
          endcase
        end
      end

      default: begin
        state_nxt = enct_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### hdl/event_notification_table_core.sv
// Top level of the event notification table: entry RAM, age list, sequencer, output register.
`default_nettype none

// Channel   Direction  Handshake           Word
// in_*      input      in_valid/in_stall   one request: op, pids, signal, event, qualifier, key
// out_*     output     out_valid/out_stall one result: status, key, notify fields, last
//
// A request is accepted while the sequencer is idle. For a teardown or signal
// event the walk over the age list reads one entry of the entry RAM per cycle,
// unless, for a signal event, a stalled output register holds it. A setup
// scans the list anew for each candidate key that it tries. Reset empties
// the table and clears the key counter; the entry RAM itself is not cleared,
// since only entries on the age list are ever read.
// A new request is taken only after the closing word of the previous one
// has been loaded into the output register.

module event_notification_table_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [enct_pkg::OP_W-1:0]    in_op,
  input  wire logic [enct_pkg::PID_W-1:0]   in_target_pid,
  input  wire logic [enct_pkg::PID_W-1:0]   in_caller_pid,
  input  wire logic [enct_pkg::SIG_W-1:0]   in_signal_number,
  input  wire logic [enct_pkg::EV_W-1:0]    in_event_type,
  input  wire logic [enct_pkg::QUAL_W-1:0]  in_qualifier,
  input  wire logic [enct_pkg::KEY_W-1:0]   in_lookup_key,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [1:0]                        out_status,
  output logic [enct_pkg::KEY_W-1:0]        out_new_key,
  output logic [enct_pkg::PID_W-1:0]        out_notify_pid,
  output logic [enct_pkg::SIG_W-1:0]        out_notify_signal,
  output logic [enct_pkg::QUAL_W-1:0]       out_notify_qualifier,
  output logic                              out_last
);

  enct_pkg::ord_cmd_t          ord_cmd;
  enct_pkg::ord_stat_t         ord_stat;
  logic [enct_pkg::IDX_W-1:0]  ord_rd_pos;
  logic                        ram_rd_en;
  logic [enct_pkg::IDX_W-1:0]  ram_rd_addr;
  enct_pkg::entry_t            ram_rd_data;
  logic                        ram_wr_en;
  logic [enct_pkg::IDX_W-1:0]  ram_wr_addr;
  enct_pkg::entry_t            ram_wr_data;
  enct_pkg::result_t           res;
  logic                        out_free;

  // Output register: loaded when the sequencer issues a word, emptied when
  // the receiver takes it. The sequencer only issues into a free register.
  logic                        out_valid_r, out_valid_nxt;
  enct_pkg::result_t           out_word_r;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_word_r <= res;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_word_r.status;
  assign out_new_key          = out_word_r.new_key;
  assign out_notify_pid       = out_word_r.pid;
  assign out_notify_signal    = out_word_r.sig;
  assign out_notify_qualifier = out_word_r.qual;
  assign out_last             = out_word_r.last;

  enct_ram #(
    .WIDTH (enct_pkg::ENTRY_W),
    .DEPTH (enct_pkg::TABLE_ENTRIES)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  enct_order u_order (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (ord_cmd),
    .rd_pos (ord_rd_pos),
    .stat   (ord_stat)
  );

  enct_seq u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_target_pid    (in_target_pid),
    .in_caller_pid    (in_caller_pid),
    .in_signal_number (in_signal_number),
    .in_event_type    (in_event_type),
    .in_qualifier     (in_qualifier),
    .in_lookup_key    (in_lookup_key),
    .ord_stat         (ord_stat),
    .ord_cmd          (ord_cmd),
    .ord_rd_pos       (ord_rd_pos),
    .ram_rd_en        (ram_rd_en),
    .ram_rd_addr      (ram_rd_addr),
    .ram_rd_data      (ram_rd_data),
    .ram_wr_en        (ram_wr_en),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data),
    .out_free         (out_free),
    .res              (res)
  );

endmodule

`default_nettype wire
